FILE: rtl/bm25_pkg.sv
// bm25_pkg: shared constants, types and helpers for the bm25 term weight pipeline
// used by bm25_front, bm25_core, bm25_back and bm25_term_weight; no dependencies
package bm25_pkg;

    // fixed-point formats
    localparam int FRAC_BITS   = 16;
    localparam int W_WIDTH     = 24;
    localparam int LOG_FB      = 28;
    localparam int LOG_W       = 5 + LOG_FB;
    localparam int Q_BITS      = 2 + LOG_FB;
    localparam int CORE_STAGES = Q_BITS;
    localparam int TA_W        = 40;
    localparam int NUM_W       = 43;
    localparam int REM_W       = 45;
    localparam int IDF_W       = 32;
    localparam int PROD_W      = 62;
    localparam int SHIFT       = 2 * LOG_FB - FRAC_BITS;

    localparam logic [28:0]         LOG10_2_Q30 = 29'd323228497;
    localparam logic [63:0]         W_MAX       = 64'd8388607;
    localparam logic [63:0]         ROUND_HALF  = 64'd1 << (SHIFT - 1);

    // register indexes
    localparam logic REG_TOTAL_DOCS = 1'b0;
    localparam logic REG_AVG_LEN    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_AVG_ZERO = 2'd1,
        ST_DF_RANGE = 2'd2
    } status_t;

    // one word in flight through the log / divide stages
    typedef struct packed {
        logic                    vld;
        status_t                 status;
        logic                    active;
        logic [31:0]             m_n;
        logic [31:0]             m_d;
        logic [4:0]              e_n;
        logic [4:0]              e_d;
        logic [LOG_FB-1:0]       f_n;
        logic [LOG_FB-1:0]       f_d;
        logic [REM_W-1:0]        rem;
        logic [NUM_W-1:0]        den;
        logic [Q_BITS-1:0]       q;
    } core_t;

    // index of the top set bit (0 when x is zero)
    function automatic logic [4:0] msb_index(input logic [31:0] x);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) idx = 5'(i);
        end
        return idx;
    endfunction

endpackage

FILE: rtl/bm25_front.sv
// bm25_front: decode stages - status check, leading-one search, normalize,
// numerator and denominator of the tf term; uses bm25_pkg
module bm25_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   in_vld,
    input  logic [15:0]            term_freq,
    input  logic [31:0]            doc_freq,
    input  logic [23:0]            doc_len,
    input  logic [31:0]            total_docs,
    input  logic [23:0]            avg_len,
    output bm25_pkg::core_t        front_out
);

    logic                          f1_vld_reg;
    bm25_pkg::status_t             f1_status_reg, f1_status_next;
    logic                          f1_active_reg, f1_active_next;
    logic [31:0]                   f1_n_reg, f1_df_reg;
    logic [4:0]                    f1_en_reg, f1_ed_reg;
    logic [bm25_pkg::TA_W-1:0]     f1_ta_reg;
    logic [23:0]                   f1_a_reg, f1_len_reg;
    bm25_pkg::core_t               out_reg, out_next;
    logic [bm25_pkg::NUM_W-1:0]    ta_ext;

    // status and compute-enable
    always_comb begin
        if (avg_len == 24'd0) begin
            f1_status_next = bm25_pkg::ST_AVG_ZERO;
        end else if (doc_freq > total_docs) begin
            f1_status_next = bm25_pkg::ST_DF_RANGE;
        end else begin
            f1_status_next = bm25_pkg::ST_OK;
        end
        f1_active_next = (f1_status_next == bm25_pkg::ST_OK) &&
                         (doc_freq != 32'd0) && (term_freq != 16'd0);
    end

    // stage 1: capture, leading one, tf*avg product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (advance) begin
            f1_vld_reg <= in_vld;
        end
        if (advance) begin
            f1_status_reg <= f1_status_next;
            f1_active_reg <= f1_active_next;
            f1_n_reg      <= total_docs;
            f1_df_reg     <= doc_freq;
            f1_en_reg     <= bm25_pkg::msb_index(total_docs);
            f1_ed_reg     <= bm25_pkg::msb_index(doc_freq);
            f1_ta_reg     <= bm25_pkg::TA_W'(term_freq) * bm25_pkg::TA_W'(avg_len);
            f1_a_reg      <= avg_len;
            f1_len_reg    <= doc_len;
        end
    end

    // stage 2: normalize mantissas, num = 6*tf*a, den = 2*tf*a + a + 3*len
    assign ta_ext = bm25_pkg::NUM_W'(f1_ta_reg);

    always_comb begin
        out_next        = '0;
        out_next.vld    = f1_vld_reg;
        out_next.status = f1_status_reg;
        out_next.active = f1_active_reg;
        out_next.m_n    = f1_n_reg << (5'd31 - f1_en_reg);
        out_next.m_d    = f1_df_reg << (5'd31 - f1_ed_reg);
        out_next.e_n    = f1_en_reg;
        out_next.e_d    = f1_ed_reg;
        out_next.rem    = bm25_pkg::REM_W'((ta_ext << 2) + (ta_ext << 1));
        out_next.den    = (ta_ext << 1) + bm25_pkg::NUM_W'(f1_a_reg)
                        + bm25_pkg::NUM_W'(f1_len_reg)
                        + (bm25_pkg::NUM_W'(f1_len_reg) << 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else if (advance) begin
            out_reg <= out_next;
        end
    end

    assign front_out = out_reg;

endmodule

FILE: rtl/bm25_core.sv
// bm25_core: one stage per bit - log2 mantissa squaring for both operands and
// restoring division for the tf term; uses bm25_pkg
module bm25_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  bm25_pkg::core_t   core_in,
    output bm25_pkg::core_t   core_out
);

    bm25_pkg::core_t stg_in   [bm25_pkg::CORE_STAGES];
    bm25_pkg::core_t stg_next [bm25_pkg::CORE_STAGES];
    bm25_pkg::core_t stg_reg  [bm25_pkg::CORE_STAGES];

    for (genvar i = 0; i < bm25_pkg::CORE_STAGES; i++) begin : g_stage
        if (i == 0) begin : g_first
            assign stg_in[i] = core_in;
        end else begin : g_chain
            assign stg_in[i] = stg_reg[i-1];
        end

        // one squaring round per operand (first LOG_FB stages only) and one quotient bit
        always_comb begin
            logic [63:0]               sq_n;
            logic [63:0]               sq_d;
            logic [bm25_pkg::REM_W-1:0] rem_s;
            logic [bm25_pkg::REM_W-1:0] trial;
            stg_next[i] = stg_in[i];
            sq_n = 64'(stg_in[i].m_n) * 64'(stg_in[i].m_n);
            sq_d = 64'(stg_in[i].m_d) * 64'(stg_in[i].m_d);
            sq_n = sq_n >> 31;
            sq_d = sq_d >> 31;
            if (i < bm25_pkg::LOG_FB) begin
                if (sq_n[32]) begin
                    stg_next[i].m_n = sq_n[32:1];
                    stg_next[i].f_n = {stg_in[i].f_n[bm25_pkg::LOG_FB-2:0], 1'b1};
                end else begin
                    stg_next[i].m_n = sq_n[31:0];
                    stg_next[i].f_n = {stg_in[i].f_n[bm25_pkg::LOG_FB-2:0], 1'b0};
                end
                if (sq_d[32]) begin
                    stg_next[i].m_d = sq_d[32:1];
                    stg_next[i].f_d = {stg_in[i].f_d[bm25_pkg::LOG_FB-2:0], 1'b1};
                end else begin
                    stg_next[i].m_d = sq_d[31:0];
                    stg_next[i].f_d = {stg_in[i].f_d[bm25_pkg::LOG_FB-2:0], 1'b0};
                end
            end
            // two integer quotient bits first, then fraction bits
            trial = (i == 0) ? (bm25_pkg::REM_W'(stg_in[i].den) << 1)
                             : bm25_pkg::REM_W'(stg_in[i].den);
            rem_s = (i < 2) ? stg_in[i].rem : (stg_in[i].rem << 1);
            if (rem_s >= trial) begin
                stg_next[i].rem = rem_s - trial;
                stg_next[i].q   = {stg_in[i].q[bm25_pkg::Q_BITS-2:0], 1'b1};
            end else begin
                stg_next[i].rem = rem_s;
                stg_next[i].q   = {stg_in[i].q[bm25_pkg::Q_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_reg[i].vld <= 1'b0;
            end else if (advance) begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    assign core_out = stg_reg[bm25_pkg::CORE_STAGES-1];

endmodule

FILE: rtl/bm25_back.sv
// bm25_back: idf from the log difference, idf * tfn product, rounding and
// saturation; uses bm25_pkg
module bm25_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  bm25_pkg::core_t               back_in,
    output logic                          back_vld,
    output logic [bm25_pkg::W_WIDTH-1:0]  back_weight,
    output bm25_pkg::status_t             back_status
);

    logic                          b1_vld_reg, b2_vld_reg, b3_vld_reg;
    bm25_pkg::status_t             b1_status_reg, b2_status_reg, b3_status_reg;
    logic                          b1_active_reg, b2_active_reg, b3_active_reg;
    logic [bm25_pkg::LOG_W-1:0]    b1_d_reg, b1_d_next;
    logic [bm25_pkg::Q_BITS-1:0]   b1_q_reg, b2_q_reg;
    logic [bm25_pkg::IDF_W-1:0]    b2_idf_reg;
    logic [bm25_pkg::PROD_W-1:0]   b3_prod_reg;
    logic [bm25_pkg::LOG_W-1:0]    ln, ld;
    logic [61:0]                   idf_full;
    logic [63:0]                   rounded;

    // log difference, clamped at zero
    assign ln = {back_in.e_n, back_in.f_n};
    assign ld = {back_in.e_d, back_in.f_d};
    assign b1_d_next = (ln > ld) ? (ln - ld) : '0;

    assign idf_full = 62'(b1_d_reg) * 62'(bm25_pkg::LOG10_2_Q30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
        end else if (advance) begin
            b1_vld_reg <= back_in.vld;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
        end
        if (advance) begin
            b1_status_reg <= back_in.status;
            b1_active_reg <= back_in.active;
            b1_d_reg      <= b1_d_next;
            b1_q_reg      <= back_in.q;
            b2_status_reg <= b1_status_reg;
            b2_active_reg <= b1_active_reg;
            b2_idf_reg    <= idf_full[61:30];
            b2_q_reg      <= b1_q_reg;
            b3_status_reg <= b2_status_reg;
            b3_active_reg <= b2_active_reg;
            b3_prod_reg   <= bm25_pkg::PROD_W'(b2_idf_reg) * bm25_pkg::PROD_W'(b2_q_reg);
        end
    end

    // round half up, saturate, zero when not computed
    assign rounded = (64'(b3_prod_reg) + bm25_pkg::ROUND_HALF) >> bm25_pkg::SHIFT;

    always_comb begin
        if (!b3_active_reg) begin
            back_weight = '0;
        end else if (rounded > bm25_pkg::W_MAX) begin
            back_weight = bm25_pkg::W_WIDTH'(bm25_pkg::W_MAX);
        end else begin
            back_weight = rounded[bm25_pkg::W_WIDTH-1:0];
        end
    end

    assign back_vld    = b3_vld_reg;
    assign back_status = b3_status_reg;

endmodule

FILE: rtl/bm25_term_weight.sv
// bm25_term_weight: top level - config registers, pipeline, output register
// depends on bm25_pkg, bm25_front, bm25_core, bm25_back
//
// Okapi BM25 term weight, k = 2.0, b = 0.75, one word per input word.
// Input channel s_*: term_freq, doc_freq, doc_len with valid/ready.
// Output channel m_*: weight (signed, 16 fraction bits) and status
// (0 ok, 1 average length zero, 2 doc_freq above total_docs).
// Config port: cfg_wr_en, cfg_addr (0 total_docs, 1 avg_doc_len), cfg_wdata;
// write only while no word is in flight.
// Throughput: one word per cycle while the receiver does not stall. Pipeline: 36
// register stages from the accepted input word to m_valid: 2 decode
// stages, 30 stages of log squaring / quotient bits (one quotient bit per
// stage), 3 stages of log difference, idf and product multiply, and the
// output register.
// The whole pipeline advances when the output register is empty or being
// taken; when the receiver stalls with a word waiting, every stage holds and
// s_ready drops.
// Reset clears all valid bits, total_docs to 0 and avg_doc_len to 1.
module bm25_term_weight (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [15:0]                   s_term_freq,
    input  logic [31:0]                   s_doc_freq,
    input  logic [23:0]                   s_doc_len,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [23:0]            m_weight,
    output logic [1:0]                    m_status
);

    logic [31:0]                   total_docs_reg;
    logic [23:0]                   avg_len_reg;
    logic                          advance;
    bm25_pkg::core_t               front_out, core_out;
    logic                          back_vld;
    logic [bm25_pkg::W_WIDTH-1:0]  back_weight;
    bm25_pkg::status_t             back_status;
    logic                          m_valid_reg;
    logic [23:0]                   m_weight_reg;
    bm25_pkg::status_t             m_status_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_docs_reg <= 32'd0;
            avg_len_reg    <= 24'd1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bm25_pkg::REG_TOTAL_DOCS: total_docs_reg <= cfg_wdata;
                bm25_pkg::REG_AVG_LEN:    avg_len_reg    <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // global pipeline enable
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    bm25_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_vld     (s_valid),
        .term_freq  (s_term_freq),
        .doc_freq   (s_doc_freq),
        .doc_len    (s_doc_len),
        .total_docs (total_docs_reg),
        .avg_len    (avg_len_reg),
        .front_out  (front_out)
    );

    bm25_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .core_in  (front_out),
        .core_out (core_out)
    );

    bm25_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .back_in     (core_out),
        .back_vld    (back_vld),
        .back_weight (back_weight),
        .back_status (back_status)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= back_vld;
        end
        if (advance) begin
            m_weight_reg <= back_weight;
            m_status_reg <= back_status;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_weight = m_weight_reg;
    assign m_status = m_status_reg;

    // an error word never carries a weight
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != bm25_pkg::ST_OK) |-> (m_weight == 24'sd0))
        else $error("nonzero weight with error status");

    // weight is never negative
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_weight[23])
        else $error("negative weight");

    // an accepted word enters the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> u_front.f1_vld_reg)
        else $error("accepted word lost at entry");

    // a stalled pipeline holds the last core stage and the last back stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(core_out.vld) && $stable(back_vld))
        else $error("pipeline moved during stall");

endmodule
